@@ src/rfrm_pkg.sv @@
// ----------------------------------------------------------------------------
// rfrm_pkg
// shared widths, constants and types of the rolling frame rate meter
// ----------------------------------------------------------------------------
package rfrm_pkg;

    localparam int WINDOW    = 60;
    localparam int TS_W      = 63;
    localparam int IVL_W     = 32;
    localparam int RATE_W    = 24;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOT_W     = IVL_W + CNT_W;
    localparam int NSQ_W     = 38;
    localparam int NUM_W     = NSQ_W + CNT_W;
    localparam int DIV_W     = TOT_W + RATE_W - 1;
    localparam int CMP_W     = TOT_W + RATE_W;
    localparam int STEP_W    = $clog2(RATE_W);

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [NSQ_W-1:0] NS_PER_S_Q8 = NSQ_W'(64'd256000000000);

    typedef struct packed {
        logic             first;
        logic [IVL_W-1:0] ivl;
    } t_q_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

@@ src/rfrm_ram.sv @@
// ----------------------------------------------------------------------------
// rfrm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rfrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/rfrm_front.sv @@
// ----------------------------------------------------------------------------
// rfrm_front
// takes timestamps, measures the frame interval and hands it to the queue
// ----------------------------------------------------------------------------
module rfrm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rfrm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // timestamp_ns
    output logic                             o_push_valid,
    output rfrm_pkg::t_q_entry               o_push_entry,
    input  logic                             i_push_ready
);

    logic [rfrm_pkg::TS_W-1:0] r_prev;
    logic                      r_started;
    logic [rfrm_pkg::TS_W-1:0] w_now;
    logic [rfrm_pkg::TS_W:0]   w_diff;
    logic                      w_accept;

    assign w_now    = s_axis_tdata[rfrm_pkg::TS_W-1:0];
    assign w_diff   = {1'b0, w_now} - {1'b0, r_prev};
    assign w_accept = s_axis_tvalid && i_push_ready;

    assign s_axis_tready = i_push_ready;
    assign o_push_valid  = s_axis_tvalid;

    always_comb begin
        o_push_entry.first = !r_started;
        if (w_diff[rfrm_pkg::TS_W]) begin
            o_push_entry.ivl = '0;
        end else if (|w_diff[rfrm_pkg::TS_W-1:rfrm_pkg::IVL_W]) begin
            o_push_entry.ivl = '1;
        end else begin
            o_push_entry.ivl = w_diff[rfrm_pkg::IVL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_started <= 1'b0;
        end else if (w_accept) begin
            r_prev    <= w_now;
            r_started <= 1'b1;
        end
    end

endmodule

@@ src/rfrm_queue.sv @@
// ----------------------------------------------------------------------------
// rfrm_queue
// two entry queue between the interval front end and the rate back end
// ----------------------------------------------------------------------------
module rfrm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  rfrm_pkg::t_q_entry i_push_entry,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output rfrm_pkg::t_q_entry o_pop_entry,
    input  logic               i_pop
);

    rfrm_pkg::t_q_entry              r_buf [rfrm_pkg::Q_DEPTH];
    logic [rfrm_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [rfrm_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [rfrm_pkg::Q_CNT_W-1:0]    r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_push_ready = (r_count != rfrm_pkg::Q_CNT_W'(rfrm_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_buf[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + rfrm_pkg::Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + rfrm_pkg::Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + rfrm_pkg::Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - rfrm_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

@@ src/rfrm_back.sv @@
// ----------------------------------------------------------------------------
// rfrm_back
// keeps the interval ring and running sum, divides to get the rate
// ----------------------------------------------------------------------------
module rfrm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pop_valid,
    input  rfrm_pkg::t_q_entry               i_pop_entry,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rfrm_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // rate_q8
    output logic [rfrm_pkg::M_TUSER_W-1:0]   m_axis_tuser   // rate_valid, saturated
);

    rfrm_pkg::t_back_state            r_state, n_state;
    logic [rfrm_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic [rfrm_pkg::CNT_W-1:0]       r_count, n_count;
    logic [rfrm_pkg::TOT_W-1:0]       r_total, n_total;
    logic [rfrm_pkg::IVL_W-1:0]       r_ivl, n_ivl;
    logic [rfrm_pkg::NUM_W-1:0]       r_rem, n_rem;
    logic [rfrm_pkg::DIV_W-1:0]       r_div, n_div;
    logic [rfrm_pkg::RATE_W-1:0]      r_quo, n_quo;
    logic [rfrm_pkg::STEP_W-1:0]      r_step, n_step;
    logic [rfrm_pkg::RATE_W-1:0]      r_res_rate, n_res_rate;
    logic                             r_res_valid, n_res_valid;
    logic                             r_res_sat, n_res_sat;
    logic                             r_out_valid, n_out_valid;
    logic [rfrm_pkg::RATE_W-1:0]      r_out_rate, n_out_rate;
    logic                             r_out_rv, n_out_rv;
    logic                             r_out_sat, n_out_sat;

    logic                             w_rd_en;
    logic                             w_wr_en;
    logic [rfrm_pkg::IVL_W-1:0]       w_old;
    logic                             w_full;
    logic                             w_ge;
    logic                             w_ovf;

    rfrm_ram #(
        .WIDTH (rfrm_pkg::IVL_W),
        .DEPTH (rfrm_pkg::WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_ivl),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_slot),
        .o_rd_data (w_old)
    );

    assign w_full = (r_count == rfrm_pkg::CNT_W'(rfrm_pkg::WINDOW));
    assign w_ge   = rfrm_pkg::CMP_W'(r_rem) >= rfrm_pkg::CMP_W'(r_div);
    assign w_ovf  = rfrm_pkg::CMP_W'(r_rem) >= {r_total, {rfrm_pkg::RATE_W{1'b0}}};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rate;
    assign m_axis_tuser  = {r_out_sat, r_out_rv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfrm_pkg::ST_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ivl       <= n_ivl;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_res_rate  <= n_res_rate;
        r_res_valid <= n_res_valid;
        r_res_sat   <= n_res_sat;
        r_out_rate  <= n_out_rate;
        r_out_rv    <= n_out_rv;
        r_out_sat   <= n_out_sat;
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_count     = r_count;
        n_total     = r_total;
        n_ivl       = r_ivl;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_step      = r_step;
        n_res_rate  = r_res_rate;
        n_res_valid = r_res_valid;
        n_res_sat   = r_res_sat;
        n_out_valid = r_out_valid;
        n_out_rate  = r_out_rate;
        n_out_rv    = r_out_rv;
        n_out_sat   = r_out_sat;
        o_pop       = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rfrm_pkg::ST_IDLE: begin
                if (i_pop_valid) begin
                    o_pop   = 1'b1;
                    w_rd_en = 1'b1;
                    n_ivl   = i_pop_entry.ivl;
                    if (i_pop_entry.first) begin
                        n_res_rate  = '0;
                        n_res_valid = 1'b0;
                        n_res_sat   = 1'b0;
                        n_state     = rfrm_pkg::ST_DONE;
                    end else begin
                        n_state = rfrm_pkg::ST_UPDATE;
                    end
                end
            end
            rfrm_pkg::ST_UPDATE: begin
                // drop the oldest interval once the ring is full
                w_wr_en = 1'b1;
                n_total = r_total - (w_full ? rfrm_pkg::TOT_W'(w_old) : '0)
                          + rfrm_pkg::TOT_W'(r_ivl);
                if (!w_full) begin
                    n_count = r_count + rfrm_pkg::CNT_W'(1);
                end
                if (r_slot == rfrm_pkg::SLOT_W'(rfrm_pkg::WINDOW - 1)) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + rfrm_pkg::SLOT_W'(1);
                end
                n_state = rfrm_pkg::ST_MUL;
            end
            rfrm_pkg::ST_MUL: begin
                n_res_valid = 1'b1;
                if (r_total == '0) begin
                    n_res_rate = '1;
                    n_res_sat  = 1'b1;
                    n_state    = rfrm_pkg::ST_DONE;
                end else begin
                    n_rem   = rfrm_pkg::NUM_W'(r_count)
                              * rfrm_pkg::NUM_W'(rfrm_pkg::NS_PER_S_Q8);
                    n_state = rfrm_pkg::ST_CHECK;
                end
            end
            rfrm_pkg::ST_CHECK: begin
                if (w_ovf) begin
                    n_res_rate = '1;
                    n_res_sat  = 1'b1;
                    n_state    = rfrm_pkg::ST_DONE;
                end else begin
                    n_div   = {r_total, {(rfrm_pkg::RATE_W - 1){1'b0}}};
                    n_quo   = '0;
                    n_step  = rfrm_pkg::STEP_W'(rfrm_pkg::RATE_W - 1);
                    n_state = rfrm_pkg::ST_DIV;
                end
            end
            rfrm_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (w_ge) begin
                    n_rem = r_rem - rfrm_pkg::NUM_W'(r_div);
                end
                n_quo = {r_quo[rfrm_pkg::RATE_W-2:0], w_ge};
                n_div = r_div >> 1;
                if (r_step == '0) begin
                    n_res_rate = n_quo;
                    n_res_sat  = 1'b0;
                    n_state    = rfrm_pkg::ST_DONE;
                end else begin
                    n_step = r_step - rfrm_pkg::STEP_W'(1);
                end
            end
            rfrm_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = r_res_rate;
                    n_out_rv    = r_res_valid;
                    n_out_sat   = r_res_sat;
                    n_state     = rfrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rfrm_pkg::ST_IDLE;
            end
        endcase
    end

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("running sum nonzero with empty ring");

    a_slot_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (r_slot == rfrm_pkg::SLOT_W'(r_count)))
        else $error("write slot out of step with fill count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfrm_pkg::ST_UPDATE && !w_full)
        |=> (r_count == $past(r_count) + rfrm_pkg::CNT_W'(1)))
        else $error("fill count did not advance");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_rate == '1))
        else $error("saturated word without maximum rate");

endmodule

@@ src/rolling_frame_rate_meter_top.sv @@
// ----------------------------------------------------------------------------
// rolling_frame_rate_meter_top
// average frame rate over the last WINDOW frame intervals
//
// one timestamp word in nanoseconds enters on the s_axis channel per frame;
// one rate word leaves on the m_axis channel for every timestamp taken.
// the first word after reset only latches the time and returns rate 0 with
// rate_valid low. later words store the interval in a ring and return
// frames per second as unsigned Q16.8, saturated to all ones when the summed
// time is zero or the rate does not fit.
// m_axis_tvalid rises once the back end has run queue pop with ring read,
// sum update, multiply, overflow check and a restoring divider that yields
// one quotient bit per cycle; the first word skips all steps after the pop,
// a zero sum ends at the multiply step and a rate overflow at the check.
// the back end handles one word at a time; a two entry queue lets the front
// end take words meanwhile.
// reset clears the start flag, the fill count, the ring slot and the sum;
// ring contents need no clearing. when m_axis_tready is low the result
// holds in the output register, the back end stops once it has the next
// result ready, and s_axis_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module rolling_frame_rate_meter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rfrm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // timestamp_ns
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rfrm_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // rate_q8
    output logic [rfrm_pkg::M_TUSER_W-1:0]   m_axis_tuser   // rate_valid, saturated
);

    logic               w_push_valid;
    logic               w_push_ready;
    rfrm_pkg::t_q_entry w_push_entry;
    logic               w_pop_valid;
    logic               w_pop;
    rfrm_pkg::t_q_entry w_pop_entry;

    rfrm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push_valid  (w_push_valid),
        .o_push_entry  (w_push_entry),
        .i_push_ready  (w_push_ready)
    );

    rfrm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_entry (w_push_entry),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_entry  (w_pop_entry),
        .i_pop        (w_pop)
    );

    rfrm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (w_pop_valid),
        .i_pop_entry   (w_pop_entry),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
